### sv/ucal_pkg.sv
// Shared widths, constants, types and the month table of the timestamp to calendar converter.
package ucal_pkg;

    localparam int TS_W       = 32;
    localparam int YEAR_W     = 12;
    localparam int MONTH_W    = 4;
    localparam int DAY_W      = 5;
    localparam int HOUR_W     = 5;
    localparam int MIN_W      = 6;
    localparam int SEC_W      = 6;

    localparam int NUM_STAGES = 7;

    localparam int DAYS_W     = 16;
    localparam int SOD_W      = 17;
    localparam int SOH_W      = 12;
    localparam int QUAD_W     = 6;
    localparam int DQ_W       = 11;
    localparam int DOY_W      = 9;
    localparam int YOFF_W     = 2;

    localparam logic [TS_W-1:0] LAST_VALID_SECOND = 32'd4102444799;
    localparam logic [YEAR_W-1:0] EPOCH_YEAR      = 12'd1970;

    localparam logic [25:0] DAY_RECIP  = 26'd50903317;
    localparam int          DAY_SHIFT  = 35;
    localparam logic [16:0] SECS_DAY   = 17'd86400;
    localparam logic [13:0] HOUR_RECIP = 14'd9321;
    localparam int          HOUR_SHIFT = 21;
    localparam logic [11:0] SECS_HOUR  = 12'd3600;
    localparam logic [10:0] MIN_RECIP  = 11'd1093;
    localparam int          MIN_SHIFT  = 14;
    localparam logic [5:0]  SECS_MIN   = 6'd60;
    localparam logic [15:0] QUAD_RECIP = 16'd45934;
    localparam int          QUAD_SHIFT = 26;
    localparam logic [10:0] DAYS_QUAD  = 11'd1461;

    localparam logic [DQ_W-1:0] YEAR2_START = 11'd365;
    localparam logic [DQ_W-1:0] YEAR3_START = 11'd730;
    localparam logic [DQ_W-1:0] YEAR4_START = 11'd1096;
    localparam logic [YOFF_W-1:0] LEAP_YOFF = 2'd2;

    typedef logic [DOY_W-1:0] t_doy;

    localparam t_doy MONTH_START [12] = '{
        9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
        9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334
    };

    typedef struct packed {
        logic [NUM_STAGES-1:0] en;
    } t_pipe_ctrl;

    function automatic t_doy month_start(input logic [MONTH_W-1:0] m, input logic leap);
        t_doy base;
        base = MONTH_START[m];
        if (m >= 4'd2 && leap) begin
            base = base + 9'd1;
        end
        return base;
    endfunction

endpackage

### sv/ucal_if.sv
// Valid/ready channel interfaces for timestamps in and calendar results out.
interface ucal_in_if;
    logic                     valid;
    logic                     ready;
    logic [ucal_pkg::TS_W-1:0] seconds_since_epoch;

    modport source (output valid, output seconds_since_epoch, input ready);
    modport sink   (input valid, input seconds_since_epoch, output ready);
endinterface

interface ucal_out_if;
    logic                          valid;
    logic                          ready;
    logic [ucal_pkg::YEAR_W-1:0]   year;
    logic [ucal_pkg::MONTH_W-1:0]  month;
    logic [ucal_pkg::DAY_W-1:0]    day_of_month;
    logic [ucal_pkg::HOUR_W-1:0]   hour;
    logic [ucal_pkg::MIN_W-1:0]    minute;
    logic [ucal_pkg::SEC_W-1:0]    second;
    logic                          out_of_range;

    modport source (output valid, output year, output month, output day_of_month,
                    output hour, output minute, output second, output out_of_range,
                    input ready);
    modport sink   (input valid, input year, input month, input day_of_month,
                    input hour, input minute, input second, input out_of_range,
                    output ready);
endinterface

### sv/ucal_pipe_ctrl.sv
// Stage valid bits and per-stage load enables with bubble collapsing on stalls.
module ucal_pipe_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output ucal_pkg::t_pipe_ctrl o_ctrl
);
    import ucal_pkg::*;

    logic [NUM_STAGES-1:0] r_valid;
    logic [NUM_STAGES-1:0] n_valid;
    logic [NUM_STAGES-1:0] w_ready;
    logic [NUM_STAGES-1:0] w_prev;

    always_comb begin
        w_ready[NUM_STAGES-1] = !r_valid[NUM_STAGES-1] || i_out_ready;
        for (int k = NUM_STAGES - 2; k >= 0; k--) begin
            w_ready[k] = !r_valid[k] || w_ready[k+1];
        end
        w_prev = {r_valid[NUM_STAGES-2:0], i_in_valid};
        for (int k = 0; k < NUM_STAGES; k++) begin
            n_valid[k]   = w_ready[k] ? w_prev[k] : r_valid[k];
            o_ctrl.en[k] = w_ready[k] && w_prev[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            r_valid <= n_valid;
        end
    end

    assign o_in_ready  = w_ready[0];
    assign o_out_valid = r_valid[NUM_STAGES-1];
endmodule

### sv/ucal_day_split.sv
// First three stages: range check, day count by reciprocal multiply, and seconds of day.
module ucal_day_split (
    input  logic                          i_clk,
    input  ucal_pkg::t_pipe_ctrl          i_ctrl,
    input  logic [ucal_pkg::TS_W-1:0]     i_ts,
    output logic [ucal_pkg::DAYS_W-1:0]   o_days,
    output logic [ucal_pkg::SOD_W-1:0]    o_sod,
    output logic                          o_oor
);
    import ucal_pkg::*;

    logic [TS_W-1:0]   r_ts1;
    logic              r_oor1;
    logic [TS_W-1:0]   r_ts2;
    logic              r_oor2;
    logic [DAYS_W-1:0] r_q2;
    logic [DAYS_W-1:0] r_days3;
    logic [SOD_W-1:0]  r_sod3;
    logic              r_oor3;

    logic [50:0] w_q_prod;
    logic [32:0] w_day_secs;
    logic [32:0] w_sod;

    assign w_q_prod   = 51'(r_ts1[TS_W-1:7]) * 51'(DAY_RECIP);
    assign w_day_secs = 33'(r_q2) * 33'(SECS_DAY);
    assign w_sod      = 33'(r_ts2) - w_day_secs;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.en[0]) begin
            r_ts1  <= i_ts;
            r_oor1 <= i_ts > LAST_VALID_SECOND;
        end
        if (i_ctrl.en[1]) begin
            r_ts2  <= r_ts1;
            r_oor2 <= r_oor1;
            r_q2   <= w_q_prod[DAY_SHIFT+DAYS_W-1:DAY_SHIFT];
        end
        if (i_ctrl.en[2]) begin
            r_days3 <= r_q2;
            r_sod3  <= w_sod[SOD_W-1:0];
            r_oor3  <= r_oor2;
        end
    end

    assign o_days = r_days3;
    assign o_sod  = r_sod3;
    assign o_oor  = r_oor3;
endmodule

### sv/ucal_tod.sv
// Stages four to seven: hour, minute and second from the seconds of the day.
module ucal_tod (
    input  logic                         i_clk,
    input  ucal_pkg::t_pipe_ctrl         i_ctrl,
    input  logic [ucal_pkg::SOD_W-1:0]   i_sod,
    output logic [ucal_pkg::HOUR_W-1:0]  o_hour,
    output logic [ucal_pkg::MIN_W-1:0]   o_minute,
    output logic [ucal_pkg::SEC_W-1:0]   o_second
);
    import ucal_pkg::*;

    logic [SOD_W-1:0]  r_sod4;
    logic [HOUR_W-1:0] r_hh4;
    logic [HOUR_W-1:0] r_hh5;
    logic [SOH_W-1:0]  r_rh5;
    logic [HOUR_W-1:0] r_hh6;
    logic [MIN_W-1:0]  r_mm6;
    logic [SOH_W-1:0]  r_rh6;
    logic [HOUR_W-1:0] r_hh7;
    logic [MIN_W-1:0]  r_mm7;
    logic [SEC_W-1:0]  r_ss7;

    logic [26:0] w_h_prod;
    logic [16:0] w_h_secs;
    logic [16:0] w_rh;
    logic [20:0] w_m_prod;
    logic [11:0] w_m_secs;
    logic [11:0] w_ss;

    function automatic logic [12:0] r_sod_hi(input logic [SOD_W-1:0] s);
        return s[SOD_W-1:4];
    endfunction

    assign w_h_prod = 27'(r_sod_hi(i_sod)) * 27'(HOUR_RECIP);
    assign w_h_secs = 17'(r_hh4) * 17'(SECS_HOUR);
    assign w_rh     = r_sod4 - w_h_secs;
    assign w_m_prod = 21'(r_rh5[SOH_W-1:2]) * 21'(MIN_RECIP);
    assign w_m_secs = 12'(r_mm6) * 12'(SECS_MIN);
    assign w_ss     = r_rh6 - w_m_secs;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.en[3]) begin
            r_sod4 <= i_sod;
            r_hh4  <= w_h_prod[HOUR_SHIFT+HOUR_W-1:HOUR_SHIFT];
        end
        if (i_ctrl.en[4]) begin
            r_hh5 <= r_hh4;
            r_rh5 <= w_rh[SOH_W-1:0];
        end
        if (i_ctrl.en[5]) begin
            r_hh6 <= r_hh5;
            r_rh6 <= r_rh5;
            r_mm6 <= w_m_prod[MIN_SHIFT+MIN_W-1:MIN_SHIFT];
        end
        if (i_ctrl.en[6]) begin
            r_hh7 <= r_hh6;
            r_mm7 <= r_mm6;
            r_ss7 <= w_ss[SEC_W-1:0];
        end
    end

    assign o_hour   = r_hh7;
    assign o_minute = r_mm7;
    assign o_second = r_ss7;
endmodule

### sv/ucal_date.sv
// Stages four to seven: four-year cycle, year within the cycle, month and day of month.
module ucal_date (
    input  logic                          i_clk,
    input  ucal_pkg::t_pipe_ctrl          i_ctrl,
    input  logic [ucal_pkg::DAYS_W-1:0]   i_days,
    input  logic                          i_oor,
    output logic [ucal_pkg::YEAR_W-1:0]   o_year,
    output logic [ucal_pkg::MONTH_W-1:0]  o_month,
    output logic [ucal_pkg::DAY_W-1:0]    o_day,
    output logic                          o_oor
);
    import ucal_pkg::*;

    logic [DAYS_W-1:0]  r_days4;
    logic [QUAD_W-1:0]  r_quad4;
    logic               r_oor4;
    logic [QUAD_W-1:0]  r_quad5;
    logic [DQ_W-1:0]    r_dq5;
    logic               r_oor5;
    logic [YEAR_W-1:0]  r_year6;
    logic [DOY_W-1:0]   r_doy6;
    logic               r_leap6;
    logic               r_oor6;
    logic [YEAR_W-1:0]  r_year7;
    logic [MONTH_W-1:0] r_month7;
    logic [DAY_W-1:0]   r_day7;
    logic               r_oor7;

    logic [31:0]        w_q_prod;
    logic [16:0]        w_quad_days;
    logic [16:0]        w_dq;
    logic [YOFF_W-1:0]  w_yoff;
    logic [DQ_W-1:0]    w_ystart;
    logic [DQ_W-1:0]    w_doy;
    logic [YEAR_W-1:0]  w_year;
    logic [MONTH_W-1:0] w_midx;
    logic [DOY_W-1:0]   w_mday;

    assign w_q_prod    = 32'(i_days) * 32'(QUAD_RECIP);
    assign w_quad_days = 17'(r_quad4) * 17'(DAYS_QUAD);
    assign w_dq        = 17'(r_days4) - w_quad_days;

    always_comb begin
        w_yoff = YOFF_W'(r_dq5 >= YEAR2_START) + YOFF_W'(r_dq5 >= YEAR3_START)
               + YOFF_W'(r_dq5 >= YEAR4_START);
        case (w_yoff)
            2'd0:    w_ystart = '0;
            2'd1:    w_ystart = YEAR2_START;
            2'd2:    w_ystart = YEAR3_START;
            default: w_ystart = YEAR4_START;
        endcase
        w_doy  = r_dq5 - w_ystart;
        w_year = EPOCH_YEAR + YEAR_W'({r_quad5, 2'b00}) + YEAR_W'(w_yoff);
    end

    always_comb begin
        w_midx = '0;
        for (int k = 1; k < 12; k++) begin
            if (r_doy6 >= month_start(MONTH_W'(k), r_leap6)) begin
                w_midx = w_midx + 4'd1;
            end
        end
        w_mday = r_doy6 - month_start(w_midx, r_leap6) + 9'd1;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.en[3]) begin
            r_days4 <= i_days;
            r_quad4 <= w_q_prod[QUAD_SHIFT+QUAD_W-1:QUAD_SHIFT];
            r_oor4  <= i_oor;
        end
        if (i_ctrl.en[4]) begin
            r_quad5 <= r_quad4;
            r_dq5   <= w_dq[DQ_W-1:0];
            r_oor5  <= r_oor4;
        end
        if (i_ctrl.en[5]) begin
            r_year6 <= w_year;
            r_doy6  <= w_doy[DOY_W-1:0];
            r_leap6 <= w_yoff == LEAP_YOFF;
            r_oor6  <= r_oor5;
        end
        if (i_ctrl.en[6]) begin
            r_year7  <= r_year6;
            r_month7 <= w_midx + 4'd1;
            r_day7   <= w_mday[DAY_W-1:0];
            r_oor7   <= r_oor6;
        end
    end

    assign o_year  = r_year7;
    assign o_month = r_month7;
    assign o_day   = r_day7;
    assign o_oor   = r_oor7;
endmodule

### sv/unix_time_to_calendar.sv
// Top level: Unix timestamp to UTC calendar date and time, seven-stage pipeline.
// A result passes the stage registers in order and shows valid when it reaches the last one.
// Throughput is one timestamp per cycle unless the output stalls; each stage loads when it
// is empty or its successor moves, so bubbles fill while a result waits at the output register.
// Synchronous active-low reset clears all stage valid bits; data registers keep values.
module unix_time_to_calendar (
    input  logic   i_clk,
    input  logic   i_rst_n,
    ucal_in_if.sink    i_in,
    ucal_out_if.source o_out
);
    import ucal_pkg::*;

    t_pipe_ctrl         w_ctrl;
    logic               w_in_ready;
    logic               w_out_valid;
    logic [DAYS_W-1:0]  w_days;
    logic [SOD_W-1:0]   w_sod;
    logic               w_oor3;
    logic [YEAR_W-1:0]  w_year;
    logic [MONTH_W-1:0] w_month;
    logic [DAY_W-1:0]   w_day;
    logic               w_oor;
    logic [HOUR_W-1:0]  w_hour;
    logic [MIN_W-1:0]   w_minute;
    logic [SEC_W-1:0]   w_second;

    ucal_pipe_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (w_in_ready),
        .o_out_valid (w_out_valid),
        .i_out_ready (o_out.ready),
        .o_ctrl      (w_ctrl)
    );

    ucal_day_split u_split (
        .i_clk  (i_clk),
        .i_ctrl (w_ctrl),
        .i_ts   (i_in.seconds_since_epoch),
        .o_days (w_days),
        .o_sod  (w_sod),
        .o_oor  (w_oor3)
    );

    ucal_tod u_tod (
        .i_clk    (i_clk),
        .i_ctrl   (w_ctrl),
        .i_sod    (w_sod),
        .o_hour   (w_hour),
        .o_minute (w_minute),
        .o_second (w_second)
    );

    ucal_date u_date (
        .i_clk   (i_clk),
        .i_ctrl  (w_ctrl),
        .i_days  (w_days),
        .i_oor   (w_oor3),
        .o_year  (w_year),
        .o_month (w_month),
        .o_day   (w_day),
        .o_oor   (w_oor)
    );

    assign i_in.ready         = w_in_ready;
    assign o_out.valid        = w_out_valid;
    assign o_out.out_of_range = w_oor;
    assign o_out.year         = w_oor ? '0 : w_year;
    assign o_out.month        = w_oor ? '0 : w_month;
    assign o_out.day_of_month = w_oor ? '0 : w_day;
    assign o_out.hour         = w_oor ? '0 : w_hour;
    assign o_out.minute       = w_oor ? '0 : w_minute;
    assign o_out.second       = w_oor ? '0 : w_second;
endmodule

### sv/ucal_checker.sv
// Port-level assertions for the converter and the bind that attaches them.
module ucal_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_out_valid,
    input logic                          i_out_ready,
    input logic [ucal_pkg::YEAR_W-1:0]   i_year,
    input logic [ucal_pkg::MONTH_W-1:0]  i_month,
    input logic [ucal_pkg::DAY_W-1:0]    i_day,
    input logic [ucal_pkg::HOUR_W-1:0]   i_hour,
    input logic [ucal_pkg::MIN_W-1:0]    i_minute,
    input logic [ucal_pkg::SEC_W-1:0]    i_second,
    input logic                          i_oor
);
    import ucal_pkg::*;

    a_valid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("Result valid dropped while stalled.");

    a_payload_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_year) && $stable(i_month)
            && $stable(i_day) && $stable(i_hour) && $stable(i_minute)
            && $stable(i_second) && $stable(i_oor))
        else $error("Result changed while stalled.");

    a_oor_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_oor |-> i_year == '0 && i_month == '0 && i_day == '0
            && i_hour == '0 && i_minute == '0 && i_second == '0)
        else $error("Out-of-range result carries nonzero fields.");

    a_fields_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_oor |-> i_year >= 12'd1970 && i_year <= 12'd2099
            && i_month >= 4'd1 && i_month <= 4'd12 && i_day >= 5'd1
            && i_hour <= 5'd23 && i_minute <= 6'd59 && i_second <= 6'd59)
        else $error("Calendar field outside its legal range.");
endmodule

bind unix_time_to_calendar ucal_checker u_ucal_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_year      (o_out.year),
    .i_month     (o_out.month),
    .i_day       (o_out.day_of_month),
    .i_hour      (o_out.hour),
    .i_minute    (o_out.minute),
    .i_second    (o_out.second),
    .i_oor       (o_out.out_of_range)
);

### tb/sv/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the Unix timestamp to UTC calendar converter.
module tb;
    import ucal_pkg::*;

    localparam int unsigned DAY_SECS    = 86400;
    localparam int unsigned HOUR_SECS   = 3600;
    localparam int unsigned MIN_SECS    = 60;
    localparam int unsigned MONTH_DAYS [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
    localparam int          LIMIT_CYCLES = 100000;
    localparam int          HOLD_CYCLES  = 150;

    typedef struct packed {
        logic [YEAR_W-1:0]  year;
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day_of_month;
        logic [HOUR_W-1:0]  hour;
        logic [MIN_W-1:0]   minute;
        logic [SEC_W-1:0]   second;
        logic               out_of_range;
    } t_calendar;

    logic clk;
    logic rst_n;

    ucal_in_if  in_ch ();
    ucal_out_if out_ch ();

    unix_time_to_calendar DUT (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source)
    );

    t_calendar   expected_dates [$];
    int          mismatches     = 0;
    int          dates_checked  = 0;
    int          beyond_2099    = 0;
    int          stamps_sent    = 0;
    int          cycle_count    = 0;
    int unsigned earliest_year  = 4095;
    int unsigned latest_year    = 0;
    bit          idle_on        = 1'b1;
    bit          hold_req       = 1'b0;

    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic int unsigned year_days(input int unsigned yr);
        return (yr % 4 == 0) ? 366 : 365;
    endfunction

    function automatic int unsigned month_days(input int unsigned yr, input int unsigned mon);
        if (mon == 1 && yr % 4 == 0) begin
            return 29;
        end
        return MONTH_DAYS[mon];
    endfunction

    function automatic t_calendar to_calendar(input logic [TS_W-1:0] ts);
        t_calendar   cal;
        int unsigned day_num;
        int unsigned sod;
        int unsigned yr;
        int unsigned mon;
        cal = '0;
        if (ts > LAST_VALID_SECOND) begin
            cal.out_of_range = 1'b1;
            return cal;
        end
        day_num = ts / DAY_SECS;
        sod     = ts % DAY_SECS;
        cal.hour   = HOUR_W'(sod / HOUR_SECS);
        cal.minute = MIN_W'((sod % HOUR_SECS) / MIN_SECS);
        cal.second = SEC_W'(sod % MIN_SECS);
        yr = EPOCH_YEAR;
        while (day_num >= year_days(yr)) begin
            day_num -= year_days(yr);
            yr++;
        end
        mon = 0;
        while (mon < 11 && day_num >= month_days(yr, mon)) begin
            day_num -= month_days(yr, mon);
            mon++;
        end
        cal.year         = YEAR_W'(yr);
        cal.month        = MONTH_W'(mon + 1);
        cal.day_of_month = DAY_W'(day_num + 1);
        return cal;
    endfunction

    function automatic int unsigned days_to_month_start(input int unsigned yr,
                                                        input int unsigned mon);
        int unsigned total;
        total = 0;
        for (int unsigned y = EPOCH_YEAR; y < yr; y++) begin
            total += year_days(y);
        end
        for (int unsigned m = 0; m < mon; m++) begin
            total += month_days(yr, m);
        end
        return total;
    endfunction

    // Lands within an hour of a month start, which also covers year starts and leap days.
    function automatic logic [TS_W-1:0] near_month_start();
        int unsigned base;
        int          offset;
        base   = days_to_month_start($urandom_range(2099, 1970), $urandom_range(11, 0)) * DAY_SECS;
        offset = int'($urandom_range(7200, 0)) - 3600;
        if (base == 0 && offset < 0) begin
            offset = -offset;
        end
        return base + offset;
    endfunction

    function automatic logic [TS_W-1:0] random_stamp();
        int unsigned pick;
        pick = $urandom_range(99, 0);
        if (pick < 55) begin
            return $urandom_range(LAST_VALID_SECOND, 0);
        end else if (pick < 80) begin
            return near_month_start();
        end else if (pick < 90) begin
            return $urandom_range(46 * DAY_SECS, 0) + (LAST_VALID_SECOND - 45 * DAY_SECS);
        end
        return $urandom_range(32'hFFFF_FFFF, LAST_VALID_SECOND + 1);
    endfunction

    task automatic send_stamp(input logic [TS_W-1:0] ts);
        int gap;
        gap = idle_on ? $urandom_range(7, 0) : 0;
        @(negedge clk);
        if (gap > 0) begin
            in_ch.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_ch.valid               = 1'b1;
        in_ch.seconds_since_epoch = ts;
        do @(posedge clk); while (!in_ch.ready);
        stamps_sent++;
    endtask

    task automatic report_field(input string field, input int unsigned want,
                                input int unsigned got);
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
        mismatches++;
    endtask

    always @(posedge clk) begin : check_results
        t_calendar got;
        t_calendar want;
        if (rst_n) begin
            if (in_ch.valid && in_ch.ready) begin
                expected_dates.push_back(to_calendar(in_ch.seconds_since_epoch));
            end
            if (out_ch.valid && out_ch.ready) begin
                got = '{out_ch.year, out_ch.month, out_ch.day_of_month, out_ch.hour,
                        out_ch.minute, out_ch.second, out_ch.out_of_range};
                if (expected_dates.size() == 0) begin
                    $display("%0t: result transfer with no timestamp pending, actual %p",
                             $time, got);
                    mismatches++;
                end else begin
                    want = expected_dates.pop_front();
                    dates_checked++;
                    if (want.out_of_range) begin
                        beyond_2099++;
                    end else begin
                        if (want.year < earliest_year) earliest_year = want.year;
                        if (want.year > latest_year) latest_year = want.year;
                    end
                    if (got.year !== want.year)
                        report_field("year", want.year, got.year);
                    if (got.month !== want.month)
                        report_field("month", want.month, got.month);
                    if (got.day_of_month !== want.day_of_month)
                        report_field("day_of_month", want.day_of_month, got.day_of_month);
                    if (got.hour !== want.hour)
                        report_field("hour", want.hour, got.hour);
                    if (got.minute !== want.minute)
                        report_field("minute", want.minute, got.minute);
                    if (got.second !== want.second)
                        report_field("second", want.second, got.second);
                    if (got.out_of_range !== want.out_of_range)
                        report_field("out_of_range", want.out_of_range, got.out_of_range);
                end
            end
        end
    end

    initial begin : receiver
        int stall;
        out_ch.ready = 1'b0;
        @(posedge rst_n);
        forever begin
            @(negedge clk);
            if (hold_req) begin
                out_ch.ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_req = 1'b0;
            end
            stall = idle_on ? $urandom_range(7, 0) : 0;
            if (stall > 0) begin
                out_ch.ready = 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ch.ready = 1'b1;
            do @(posedge clk); while (!out_ch.valid && !hold_req);
        end
    end

    initial begin : watchdog
        while (cycle_count < LIMIT_CYCLES) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Run stopped after %0d cycles with %0d results pending.",
                 cycle_count, expected_dates.size());
        $display("tb NOT OK");
        $finish;
    end

    task automatic test_directed();
        logic [TS_W-1:0] stamps [$] = '{
            32'd0, 32'd1, 32'd59, 32'd60, 32'd3599, 32'd3600, 32'd86399, 32'd86400,
            32'd31535999, 32'd31536000, 32'd68169599, 32'd68169600, 32'd68255999,
            32'd68256000, 32'd94694399, 32'd946684800, 32'd951782400, 32'd1431655765,
            32'd2147483647, 32'd2863311530, 32'd4102358400, 32'd4102444799,
            32'd4102444800, 32'hFFFF_FFFF
        };
        foreach (stamps[i]) begin
            send_stamp(stamps[i]);
        end
    endtask

    task automatic test_random_stream(input int count);
        repeat (count) send_stamp(random_stamp());
    endtask

    task automatic test_back_to_back(input int count);
        idle_on = 1'b0;
        repeat (count) send_stamp(random_stamp());
        idle_on = 1'b1;
    endtask

    // The receiver holds off while timestamps keep coming, so the pipeline fills and stalls.
    task automatic test_backpressure(input int count);
        idle_on  = 1'b0;
        hold_req = 1'b1;
        repeat (count) send_stamp(random_stamp());
        idle_on  = 1'b1;
    endtask

    initial begin : stimulus
        rst_n                     = 1'b0;
        in_ch.valid               = 1'b0;
        in_ch.seconds_since_epoch = '0;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_random_stream(360);
        test_back_to_back(120);
        test_backpressure(50);
        test_random_stream(60);

        @(negedge clk);
        in_ch.valid = 1'b0;
        while (expected_dates.size() != 0) @(posedge clk);
        repeat (NUM_STAGES * 3) @(posedge clk);

        $display("Checked %0d of %0d timestamps, %0d beyond 2099, under random gaps, stalls,",
                 dates_checked, stamps_sent, beyond_2099);
        $display("full-rate streams and a long output hold; years %0d to %0d, %0d mismatches.",
                 earliest_year, latest_year, mismatches);
        if (mismatches == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end

endmodule

### unix_time_to_calendar.f
sv/ucal_pkg.sv
sv/ucal_if.sv
sv/ucal_pipe_ctrl.sv
sv/ucal_day_split.sv
sv/ucal_tod.sv
sv/ucal_date.sv
sv/unix_time_to_calendar.sv
sv/ucal_checker.sv
tb/sv/tb.sv
